// ----- design/pxds_pkg.sv -----
// Shared constants, widths and helper functions for the eight-to-one pixel downscaler.
// No dependencies.
`default_nettype none

package pxds_pkg;

   localparam int PIXEL_W       = 24;
   localparam int COLUMN_W      = 9;
   localparam int ROW_W         = 3;
   localparam int CHAN_W        = 8;
   localparam int SUM_W         = 11;
   localparam int CX_W          = 6;
   localparam int COLOR_W       = 12;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 16;
   localparam int COLUMNS_OUT_DEF = 64;

   localparam logic [ROW_W-1:0] ROW_FIRST   = 3'h0;
   localparam logic [ROW_W-1:0] ROW_LAST    = 3'h7;
   localparam logic [2:0]       GROUP_LAST  = 3'h7;

   function automatic logic [COLOR_W-1:0] pack_word(input logic [PIXEL_W-1:0] entry);
      pack_word = {1'b0, entry[23:21], 1'b0, entry[7:5], 1'b0, entry[15:13]};
   endfunction

   function automatic logic [CHAN_W-1:0] chan_avg(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      logic [CHAN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      chan_avg = s[CHAN_W:1];
   endfunction

endpackage

`default_nettype wire

// ----- design/pxds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; read data holds while rd_en is low.
`default_nettype none

module pxds_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/pixel_downscale_eight_to_one.sv -----
// Eight-to-one pixel binning downscaler, top level. Uses pxds_pkg and pxds_ram.
// A group-end pixel in range writes its line entry in the cycle after its acceptance.
// Throughput: one pixel word per cycle outside line emission.
// Emission: after the band-closing pixel, input stalls until every line entry has been sent; the
//   first output word passes S_SETTLE, S_EMIT, the RAM read register and the response register.
// Reset: sums and control clear; the line store is not cleared.
`default_nettype none

module pixel_downscale_eight_to_one #(
   parameter int COLUMNS_OUT = pxds_pkg::COLUMNS_OUT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // pixel[23:0], column[32:24], row_in_band[35:33], zero[39:36]
   input  wire logic [pxds_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // packed_color[11:0], zero[15:12]
   output logic      [pxds_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int AW    = (COLUMNS_OUT > 1) ? $clog2(COLUMNS_OUT) : 1;
   localparam int CNT_W = $clog2(COLUMNS_OUT + 1);
   localparam logic [pxds_pkg::COLUMN_W-1:0] LAST_COL =
      pxds_pkg::COLUMN_W'(8 * COLUMNS_OUT - 1);
   localparam logic [pxds_pkg::CX_W:0] COLS_LIMIT = (pxds_pkg::CX_W + 1)'(COLUMNS_OUT);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(COLUMNS_OUT);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COLUMNS_OUT - 1);

   typedef enum logic [1:0] {S_IDLE, S_SETTLE, S_EMIT} state_type;

   logic [pxds_pkg::PIXEL_W-1:0]  pixel;
   logic [pxds_pkg::COLUMN_W-1:0] column;
   logic [pxds_pkg::ROW_W-1:0]    row_in_band;
   logic [pxds_pkg::CX_W-1:0]     cx;
   logic                          req_accept, group_end, in_range, emit_start;

   logic [pxds_pkg::SUM_W-1:0] red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [pxds_pkg::SUM_W-1:0] red_add, green_add, blue_add;
   logic [pxds_pkg::SUM_W-1:0] red_sum_in, green_sum_in, blue_sum_in;

   logic                          s2_valid_ff, s2_valid_in;
   logic [AW-1:0]                 s2_addr_ff;
   logic [pxds_pkg::PIXEL_W-1:0]  s2_mean_ff;
   logic                          s2_avg_ff;

   logic                          wr_valid_ff;
   logic [AW-1:0]                 wr_addr_ff;
   logic [pxds_pkg::PIXEL_W-1:0]  wr_data_ff;

   logic [pxds_pkg::PIXEL_W-1:0]  old_entry, new_entry, rd_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic                          rd_valid_ff, rd_valid_in;
   logic                          rd_last_ff, rd_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pxds_pkg::COLOR_W-1:0]  rsp_color_ff, rsp_color_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          emit_issue, transfer, issue_done;

   assign pixel       = req_tdata[23:0];
   assign column      = req_tdata[32:24];
   assign row_in_band = req_tdata[35:33];
   assign cx          = column[8:3];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign group_end  = (column[2:0] == pxds_pkg::GROUP_LAST);
   assign in_range   = ({1'b0, cx} < COLS_LIMIT);
   assign emit_start = req_accept && (row_in_band == pxds_pkg::ROW_LAST) &&
                       (column == LAST_COL);

   assign red_add   = red_sum_ff   + pxds_pkg::SUM_W'(pixel[23:16]);
   assign green_add = green_sum_ff + pxds_pkg::SUM_W'(pixel[7:0]);
   assign blue_add  = blue_sum_ff  + pxds_pkg::SUM_W'(pixel[15:8]);

   always_comb begin
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      if (req_accept) begin
         if (group_end) begin
            red_sum_in   = '0;
            green_sum_in = '0;
            blue_sum_in  = '0;
         end else begin
            red_sum_in   = red_add;
            green_sum_in = green_add;
            blue_sum_in  = blue_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
      end else begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
      end
   end

   // group-end stage: read old entry, capture means
   assign s2_valid_in = req_accept && group_end && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         wr_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_in) begin
         s2_addr_ff <= cx[AW-1:0];
         s2_mean_ff <= {red_add[10:3], blue_add[10:3], green_add[10:3]};
         s2_avg_ff  <= (row_in_band != pxds_pkg::ROW_FIRST);
      end
      if (s2_valid_ff) begin
         wr_addr_ff <= s2_addr_ff;
         wr_data_ff <= new_entry;
      end
   end

   // forward the previous cycle's write, which the read did not see
   assign old_entry = (wr_valid_ff && (wr_addr_ff == s2_addr_ff)) ? wr_data_ff : rd_data;

   always_comb begin
      if (s2_avg_ff) begin
         new_entry = {pxds_pkg::chan_avg(old_entry[23:16], s2_mean_ff[23:16]),
                      pxds_pkg::chan_avg(old_entry[15:8],  s2_mean_ff[15:8]),
                      pxds_pkg::chan_avg(old_entry[7:0],   s2_mean_ff[7:0])};
      end else begin
         new_entry = s2_mean_ff;
      end
   end

   assign ram_rd_en   = s2_valid_in || emit_issue;
   assign ram_rd_addr = emit_issue ? cnt_ff[AW-1:0] : cx[AW-1:0];

   pxds_ram #(
      .WIDTH (pxds_pkg::PIXEL_W),
      .DEPTH (COLUMNS_OUT)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_addr_ff),
      .wr_data (new_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   // line emission
   assign issue_done = (cnt_ff == CNT_END);
   assign transfer   = rd_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign emit_issue = (state_ff == S_EMIT) && !issue_done && (!rd_valid_ff || transfer);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_valid_in  = rd_valid_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (transfer) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = pxds_pkg::pack_word(rd_data);
         rsp_last_in  = rd_last_ff;
         rd_valid_in  = 1'b0;
      end
      if (emit_issue) begin
         rd_valid_in = 1'b1;
         rd_last_in  = (cnt_ff == CNT_LAST);
         cnt_in      = cnt_ff + CNT_W'(1);
      end
      case (state_ff)
         S_IDLE: begin
            if (emit_start) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (issue_done && !rd_valid_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_last_ff   <= rd_last_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pxds_pkg::RSP_TDATA_W - pxds_pkg::COLOR_W){1'b0}}, rsp_color_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_no_pending_read_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rd_valid_ff)
      else $error("emission read pending while accepting pixels");

   a_no_write_during_emit_read: assert property (@(posedge clock) disable iff (reset)
      !(emit_issue && s2_valid_ff))
      else $error("emission read collides with line store write");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_END)
      else $error("emission counter overran the line");

   a_write_follows_accept: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(req_accept))
      else $error("line store write without an accepted pixel");

endmodule

`default_nettype wire
